[rtl/dssm_pkg.sv]
`timescale 1ns / 1ps

package dssm_pkg;

	// Default build sizes
	localparam int SAMPLE_DEPTH_DEF = 8192;
	localparam int VOICE_COUNT_DEF  = 3;
	localparam int VOICE_MAX        = 3;

	// Field widths
	localparam int VOICE_W  = 2;
	localparam int ADDR_W   = 13;
	localparam int SAMPLE_W = 12;
	localparam int POS_W    = 14;
	localparam int STEP_W   = 16;
	localparam int BEAT_W   = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int SUM_W    = 14;
	localparam int CNT_W    = 2;

	// Levels
	localparam logic [SAMPLE_W-1:0] LEVEL_MAX    = 12'd4095;
	localparam logic [SAMPLE_W-1:0] LEVEL_SILENT = 12'd2048;

	// Reciprocal of three: floor(x / 3) == (x * RECIP3) >> RECIP3_SH for x < 2**17
	localparam logic [15:0] RECIP3    = 16'd43691;
	localparam int          RECIP3_SH = 17;

	localparam logic [STEP_W-1:0] SPS_RESET = 16'd3214;

	// Request kinds
	localparam logic REQ_TICK = 1'b0;
	localparam logic REQ_LOAD = 1'b1;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SAMPLES_PER_STEP = 3'd0,
		CFG_KICK_PATTERN     = 3'd1,
		CFG_SNARE_PATTERN    = 3'd2,
		CFG_HAT_PATTERN      = 3'd3,
		CFG_KICK_LENGTH      = 3'd4,
		CFG_SNARE_LENGTH     = 3'd5,
		CFG_HAT_LENGTH       = 3'd6
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_SUM  = 4'b0100,
		ST_DIV  = 4'b1000
	} state_t;

endpackage

[rtl/dssm_in_if.sv]
`timescale 1ns / 1ps

interface dssm_in_if;
	logic                           valid;
	logic                           ready;
	logic                           req_type;
	logic [dssm_pkg::VOICE_W-1:0]   load_voice;
	logic [dssm_pkg::ADDR_W-1:0]    load_address;
	logic [dssm_pkg::SAMPLE_W-1:0]  load_value;

	modport source (output valid, req_type, load_voice, load_address, load_value,
		input ready);
	modport sink (input valid, req_type, load_voice, load_address, load_value,
		output ready);
endinterface

[rtl/dssm_out_if.sv]
`timescale 1ns / 1ps

interface dssm_out_if;
	logic                           valid;
	logic                           ready;
	logic [dssm_pkg::SAMPLE_W-1:0]  audio_level;
	logic [dssm_pkg::BEAT_W-1:0]    beat_position;

	modport source (output valid, audio_level, beat_position, input ready);
	modport sink (input valid, audio_level, beat_position, output ready);
endinterface

[rtl/dssm_cfg_if.sv]
`timescale 1ns / 1ps

interface dssm_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [dssm_pkg::CFG_IDX_W-1:0]  index;
	logic [dssm_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/drum_step_sequencer_mixer_top.sv]
`timescale 1ns / 1ps
// Channel   Dir  Payload                                          Request
// req_in    in   req_type, load_voice, load_address, load_value   tick or sample load
// res_out   out  audio_level, beat_position                       one per tick
// cfg       in   index, data                                      register write
//
// A load is written in the cycle it is accepted. A tick passes IDLE to accept and
// step the pattern, SCAN once per voice on the single sample memory read port, SUM
// to collect the last read and DIV for the shift or reciprocal multiply into output.
// Reset clears counters, voices and registers; the sample memory is not cleared.
// A finished result waits in the output register; the next request is accepted
// meanwhile and the block only holds in its last cycle if that register is still full.

module drum_step_sequencer_mixer_top #(
	parameter int SAMPLE_DEPTH = dssm_pkg::SAMPLE_DEPTH_DEF,
	parameter int VOICE_COUNT  = dssm_pkg::VOICE_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	dssm_in_if.sink     req_in,
	dssm_out_if.source  res_out,
	dssm_cfg_if.sink    cfg
);

	localparam int MEM_DEPTH = VOICE_COUNT * SAMPLE_DEPTH;
	localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
	localparam int XW = (AW > dssm_pkg::POS_W) ? AW : dssm_pkg::POS_W;
	localparam int DW = $clog2(SAMPLE_DEPTH + 1);
	localparam int CW = (DW > dssm_pkg::POS_W) ? DW : dssm_pkg::POS_W;

	localparam int VM = dssm_pkg::VOICE_MAX;

	// Configuration
	logic [dssm_pkg::STEP_W-1:0] sps_q;
	logic [15:0]                 pat_q [VM];
	logic [dssm_pkg::POS_W-1:0]  len_q [VM];

	// Sequencer state
	dssm_pkg::state_t             state_q;
	logic [dssm_pkg::STEP_W-1:0]  step_q;
	logic [3:0]                   ppos_q;
	logic [VM-1:0]                active_q;
	logic [dssm_pkg::POS_W-1:0]   play_q [VM];
	logic [dssm_pkg::VOICE_W-1:0] vi_q;
	logic                         rd_pend_q;
	logic [dssm_pkg::SUM_W-1:0]   sum_q;
	logic [dssm_pkg::CNT_W-1:0]   cnt_q;

	// Output register
	logic                          out_valid_q;
	logic [dssm_pkg::SAMPLE_W-1:0] level_q;
	logic [dssm_pkg::BEAT_W-1:0]   beat_q;

	// Sample memory
	logic [dssm_pkg::SAMPLE_W-1:0] mem [MEM_DEPTH];
	logic [dssm_pkg::SAMPLE_W-1:0] rdata_q;

	function automatic logic [XW-1:0] voice_base(input logic [dssm_pkg::VOICE_W-1:0] v);
		logic [XW-1:0] b;
		case (v)
			2'd1:    b = XW'(SAMPLE_DEPTH);
			2'd2:    b = XW'(2 * SAMPLE_DEPTH);
			default: b = '0;
		endcase
		return b;
	endfunction

	// Handshakes
	logic acc, tick_acc, load_acc, out_free;
	assign req_in.ready  = (state_q == dssm_pkg::ST_IDLE);
	assign acc           = req_in.valid && req_in.ready;
	assign tick_acc      = acc && (req_in.req_type == dssm_pkg::REQ_TICK);
	assign load_acc      = acc && (req_in.req_type == dssm_pkg::REQ_LOAD);
	assign cfg.ready     = 1'b1;
	assign out_free      = !out_valid_q || res_out.ready;

	assign res_out.valid         = out_valid_q;
	assign res_out.audio_level   = level_q;
	assign res_out.beat_position = beat_q;

	// Step advance on a tick
	logic [dssm_pkg::STEP_W:0] step_inc;
	logic                      fire;
	logic [3:0]                ppos_nx;
	assign step_inc = {1'b0, step_q} + 17'd1;
	assign fire     = step_inc >= {1'b0, sps_q};
	assign ppos_nx  = ppos_q + {3'b000, fire};

	// Voice scan
	logic                       cur_act, cur_play;
	logic [dssm_pkg::POS_W-1:0] cur_pos;
	logic [AW-1:0]              raddr;
	logic                       rd_en;
	assign cur_act  = active_q[vi_q];
	assign cur_pos  = play_q[vi_q];
	assign cur_play = (CW'(cur_pos) < CW'(SAMPLE_DEPTH)) && (cur_pos < len_q[vi_q]);
	assign raddr    = AW'(voice_base(vi_q) + XW'(cur_pos));
	assign rd_en    = (state_q == dssm_pkg::ST_SCAN) && cur_act && cur_play;

	// Load address check
	logic          wr_en;
	logic [AW-1:0] waddr;
	assign wr_en = load_acc
		&& (req_in.load_voice < dssm_pkg::VOICE_W'(VOICE_COUNT))
		&& (CW'(req_in.load_address) < CW'(SAMPLE_DEPTH));
	assign waddr = AW'(voice_base(req_in.load_voice) + XW'(req_in.load_address));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[waddr] <= req_in.load_value;
		end
		if (rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	// Average of the voices that played
	logic [29:0]                   prod3;
	logic [dssm_pkg::SUM_W-1:0]    avg;
	logic [dssm_pkg::SAMPLE_W-1:0] level_nx;
	assign prod3 = {16'd0, sum_q} * {14'd0, dssm_pkg::RECIP3};
	always_comb begin
		case (cnt_q)
			2'd1:    avg = sum_q;
			2'd2:    avg = sum_q >> 1;
			2'd3:    avg = dssm_pkg::SUM_W'(prod3[29:dssm_pkg::RECIP3_SH]);
			default: avg = '0;
		endcase
		if (cnt_q == 2'd0) begin
			level_nx = dssm_pkg::LEVEL_SILENT;
		end else if (avg > dssm_pkg::SUM_W'(dssm_pkg::LEVEL_MAX)) begin
			level_nx = dssm_pkg::LEVEL_MAX;
		end else begin
			level_nx = avg[dssm_pkg::SAMPLE_W-1:0];
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sps_q <= dssm_pkg::SPS_RESET;
			for (int v = 0; v < VM; v++) begin
				pat_q[v] <= '0;
				len_q[v] <= '0;
			end
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				dssm_pkg::CFG_SAMPLES_PER_STEP: sps_q    <= cfg.data;
				dssm_pkg::CFG_KICK_PATTERN:     pat_q[0] <= cfg.data;
				dssm_pkg::CFG_SNARE_PATTERN:    pat_q[1] <= cfg.data;
				dssm_pkg::CFG_HAT_PATTERN:      pat_q[2] <= cfg.data;
				dssm_pkg::CFG_KICK_LENGTH:      len_q[0] <= cfg.data[dssm_pkg::POS_W-1:0];
				dssm_pkg::CFG_SNARE_LENGTH:     len_q[1] <= cfg.data[dssm_pkg::POS_W-1:0];
				dssm_pkg::CFG_HAT_LENGTH:       len_q[2] <= cfg.data[dssm_pkg::POS_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dssm_pkg::ST_IDLE;
			step_q      <= '0;
			ppos_q      <= '0;
			active_q    <= '0;
			vi_q        <= '0;
			rd_pend_q   <= 1'b0;
			sum_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			level_q     <= '0;
			beat_q      <= '0;
			for (int v = 0; v < VM; v++) begin
				play_q[v] <= '0;
			end
		end else begin
			if ((state_q == dssm_pkg::ST_DIV) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (res_out.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				dssm_pkg::ST_IDLE: begin
					if (tick_acc) begin
						sum_q <= '0;
						cnt_q <= '0;
						vi_q  <= '0;
						state_q <= dssm_pkg::ST_SCAN;
						if (fire) begin
							step_q <= '0;
							ppos_q <= ppos_nx;
							for (int v = 0; v < VM; v++) begin
								// retrigger voices whose bit is set at the new step
								if (v < VOICE_COUNT && pat_q[v][~ppos_nx]) begin
									active_q[v] <= 1'b1;
									play_q[v]   <= '0;
								end
							end
						end else begin
							step_q <= step_inc[dssm_pkg::STEP_W-1:0];
						end
					end
				end
				dssm_pkg::ST_SCAN: begin
					if (rd_pend_q) begin
						sum_q <= sum_q + dssm_pkg::SUM_W'(rdata_q);
					end
					rd_pend_q <= rd_en;
					if (cur_act) begin
						if (cur_play) begin
							play_q[vi_q] <= cur_pos + 14'd1;
							cnt_q        <= cnt_q + 2'd1;
						end else begin
							active_q[vi_q] <= 1'b0;
						end
					end
					if (vi_q == dssm_pkg::VOICE_W'(VOICE_COUNT - 1)) begin
						state_q <= dssm_pkg::ST_SUM;
					end else begin
						vi_q <= vi_q + 2'd1;
					end
				end
				dssm_pkg::ST_SUM: begin
					// collect the read issued by the last voice
					if (rd_pend_q) begin
						sum_q <= sum_q + dssm_pkg::SUM_W'(rdata_q);
					end
					rd_pend_q <= 1'b0;
					state_q   <= dssm_pkg::ST_DIV;
				end
				dssm_pkg::ST_DIV: begin
					// hold until the output register is free
					if (out_free) begin
						level_q     <= level_nx;
						beat_q      <= ~ppos_q;
						state_q     <= dssm_pkg::ST_IDLE;
					end
				end
				default: state_q <= dssm_pkg::ST_IDLE;
			endcase
		end
	end

	// Checks
	a_pend_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_q |-> $past(state_q == dssm_pkg::ST_SCAN))
		else $error("read pending outside voice scan");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= dssm_pkg::CNT_W'(VOICE_COUNT))
		else $error("more voices counted than exist");

	a_scan_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dssm_pkg::ST_SCAN) |-> (vi_q < dssm_pkg::VOICE_W'(VOICE_COUNT)))
		else $error("voice index out of range");

	a_result_from_div: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == dssm_pkg::ST_DIV))
		else $error("result raised outside final stage");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != dssm_pkg::ST_IDLE) |-> !acc)
		else $error("request accepted while busy");

endmodule
